// File: hw/rtl/teh_pkg.sv
// types, codes and helper functions shared by the tunnel header builder
package teh_pkg;

   localparam logic OP_CREATE = 1'b0;
   localparam logic OP_PACKET = 1'b1;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_WG    = 2'd1;
   localparam logic [1:0] KIND_VXLAN = 2'd2;

   localparam logic [1:0] ST_HEADER  = 2'd0;
   localparam logic [1:0] ST_PASS    = 2'd1;
   localparam logic [1:0] ST_CREATED = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [15:0] WG_OVERHEAD    = 16'd44;
   localparam logic [15:0] VXLAN_OVERHEAD = 16'd36;
   localparam logic [15:0] IP_HDR_LEN     = 16'd20;
   localparam logic [31:0] IP_WORD0       = 32'h4500_0000;
   localparam logic [15:0] IP_TTL_PROTO   = 16'h4011;
   localparam logic [31:0] WG_TYPE_WORD   = 32'h0400_0000;
   localparam logic [31:0] VXLAN_FLAGS    = 32'h0800_0000;

   typedef struct packed {
      logic        mode;
      logic [31:0] tenant;
      logic [15:0] in_len;
      logic [1:0]  new_kind;
      logic [31:0] local_addr;
      logic [31:0] remote_addr;
      logic [15:0] udp_src;
      logic [15:0] udp_dst;
      logic [31:0] egress_port;
   } req_type;

   typedef struct packed {
      logic [31:0] header_word;
      logic        last;
      logic [1:0]  status;
      logic [1:0]  kind;
      logic [15:0] out_len;
      logic [31:0] out_iface;
      logic [11:0] tunnel_index;
   } rsp_type;

   // one classified job between front and back
   typedef struct packed {
      logic        mode;
      logic        flag;     // create: table full, packet: table empty
      logic [15:0] idx;
      logic [15:0] in_len;
      logic [1:0]  kind;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] iface;
   } job_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] iface;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_type;
   typedef enum logic [1:0] {B_IDLE, B_READ, B_SUM, B_EMIT} back_state_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [15:0] ip_checksum(input logic [15:0] len,
                                               input logic [31:0] src,
                                               input logic [31:0] dst);
      logic [19:0] s;
      logic [16:0] f;
      s = 20'h4500 + 20'(len) + 20'(IP_TTL_PROTO) + 20'(src[31:16]) + 20'(src[15:0])
          + 20'(dst[31:16]) + 20'(dst[15:0]);
      f = 17'(s[15:0]) + 17'(s[19:16]);
      f = 17'(f[15:0]) + 17'(f[16]);
      return ~f[15:0];
   endfunction

endpackage

// File: hw/rtl/tunnel_encap_header_builder_unit.sv
// top level of the tunnel encapsulation header builder
// A create transfer is queued in the cycle the classifier accepts it and answers one
// result. A packet transfer picks its tunnel as tenant mod tunnel count in a one-bit-a-cycle
// divider, used when two or more tunnels exist; then the sequencer reads the table, forms
// the checksum and emits 11 WireGuard or 9 VXLAN words on consecutive cycles; the divider
// for the next packet overlaps that emission. busy is high while the classifier divides or
// waits to push, or while the job queue is full. Results leave on rsp_valid for one cycle
// each and cannot be held off. The table needs no clearing pass after reset.
module tunnel_encap_header_builder_unit #(
   parameter int TUNNEL_ENTRIES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  teh_pkg::req_type req_item,
   output logic             rsp_valid,
   output teh_pkg::rsp_type rsp_item
);
   import teh_pkg::*;

   qstat_type qstat;
   job_type   push_job, head;
   logic      push, pop;

   teh_front #(.TUNNEL_ENTRIES(TUNNEL_ENTRIES)) u_front (
      .clock, .reset, .start, .busy, .req_item, .qstat, .push, .push_job
   );

   teh_queue u_queue (
      .clock, .reset, .push, .push_job, .pop, .head, .stat(qstat)
   );

   teh_back #(.TUNNEL_ENTRIES(TUNNEL_ENTRIES)) u_back (
      .clock, .reset, .head, .qstat, .pop, .rsp_valid, .rsp_item
   );

`ifndef SYNTHESIS
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_HEADER |-> rsp_item.last)
      else $error("non-header result without last");
   a_words_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_HEADER && !rsp_item.last |=> rsp_valid)
      else $error("gap inside header");
   a_pass_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_PASS |-> rsp_item.kind == KIND_NONE)
      else $error("passthrough with kind");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full || pop)
      else $error("queue overflow");
`endif
endmodule

// File: hw/rtl/teh_queue.sv
// two-entry job queue between classifier and header sequencer
module teh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  teh_pkg::job_type  push_job,
   input  logic              pop,
   output teh_pkg::job_type  head,
   output teh_pkg::qstat_type stat
);
   import teh_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

   assign head       = slot_ff[rd_ptr_ff];
   assign stat.empty = (fill_ff == 2'd0);
   assign stat.full  = (fill_ff == 2'd2);
endmodule

// File: hw/rtl/teh_front.sv
// request classifier: table fill count, tunnel selection by iterative modulo
module teh_front #(
   parameter int TUNNEL_ENTRIES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  teh_pkg::req_type  req_item,
   input  teh_pkg::qstat_type qstat,
   output logic              push,
   output teh_pkg::job_type  push_job
);
   import teh_pkg::*;

   localparam int CNT_W = $clog2(TUNNEL_ENTRIES + 1);
   localparam int REM_W = CNT_W + 1;

   front_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      dividend_ff, dividend_in;
   logic [REM_W-1:0] rem_ff, rem_in, rem_sh;
   logic [CNT_W-1:0] div_ff, div_in;
   logic [4:0]       step_ff, step_in;
   job_type          pend_ff, pend_in;
   job_type          new_job;
   logic             accept, is_full;
   logic [1:0]       kind_ok;

   assign busy    = (state_ff != F_IDLE) || qstat.full;
   assign accept  = start && !busy;
   assign is_full = (count_ff >= CNT_W'(TUNNEL_ENTRIES));
   assign rem_sh  = {rem_ff[REM_W-2:0], dividend_ff[31]};

   always_comb begin
      kind_ok = KIND_NONE;
      if (req_item.new_kind == KIND_WG || req_item.new_kind == KIND_VXLAN)
         kind_ok = req_item.new_kind;
      new_job.mode      = req_item.mode;
      new_job.flag      = (req_item.mode == OP_CREATE) ? is_full : (count_ff == '0);
      new_job.idx       = (req_item.mode == OP_CREATE && !is_full) ? 16'(count_ff) : 16'd0;
      new_job.in_len    = req_item.in_len;
      new_job.kind      = kind_ok;
      new_job.src_addr  = req_item.local_addr;
      new_job.dst_addr  = req_item.remote_addr;
      new_job.sport     = req_item.udp_src;
      new_job.dport     = req_item.udp_dst;
      new_job.iface     = req_item.egress_port;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      step_ff     <= step_in;
      pend_ff     <= pend_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      step_in     = step_ff;
      pend_in     = pend_ff;
      push        = 1'b0;
      push_job    = new_job;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_item.mode == OP_CREATE) begin
                  push = 1'b1;
                  if (!is_full) count_in = count_ff + CNT_W'(1);
               end else if (count_ff <= CNT_W'(1)) begin
                  push = 1'b1;
               end else begin
                  pend_in     = new_job;
                  dividend_in = req_item.tenant;
                  rem_in      = '0;
                  div_in      = count_ff;
                  step_in     = '0;
                  state_in    = F_DIV;
               end
            end
         end
         F_DIV: begin
            rem_in = (rem_sh >= REM_W'(div_ff)) ? rem_sh - REM_W'(div_ff) : rem_sh;
            dividend_in = {dividend_ff[30:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) state_in = F_PUSH;
         end
         F_PUSH: begin
            push_job     = pend_ff;
            push_job.idx = 16'(rem_ff);
            if (!qstat.full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end
endmodule

// File: hw/rtl/teh_back.sv
// header sequencer: tunnel table, packet counters and word emission
module teh_back #(
   parameter int TUNNEL_ENTRIES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  teh_pkg::job_type   head,
   input  teh_pkg::qstat_type qstat,
   output logic               pop,
   output logic               rsp_valid,
   output teh_pkg::rsp_type   rsp_item
);
   import teh_pkg::*;

   localparam int IDX_W = (TUNNEL_ENTRIES > 1) ? $clog2(TUNNEL_ENTRIES) : 1;

   entry_type   entry_mem [TUNNEL_ENTRIES];
   logic [63:0] ctr_mem   [TUNNEL_ENTRIES];
   entry_type   rd_rec_ff;
   logic [63:0] rd_ctr_ff;

   back_state_type state_ff, state_in;
   job_type     cur_ff, cur_in;
   logic [15:0] olen_ff, olen_in;
   logic [15:0] csum_ff, csum_in;
   logic [3:0]  k_ff, k_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic             ent_we, ctr_we;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [63:0]      ctr_wd;
   entry_type        wr_rec;
   logic             is_wg;
   logic [3:0]       last_k;
   logic [31:0]      word;

   assign rd_addr = head.idx[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (ent_we) entry_mem[wr_addr] <= wr_rec;
      if (pop) rd_rec_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctr_we) ctr_mem[wr_addr] <= ctr_wd;
      if (pop) rd_ctr_ff <= ctr_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      olen_ff <= olen_in;
      csum_ff <= csum_in;
      k_ff    <= k_in;
      rsp_ff  <= rsp_in;
   end

   assign is_wg  = (rd_rec_ff.kind == KIND_WG);
   assign last_k = is_wg ? 4'd10 : 4'd8;

   always_comb begin
      case (k_ff)
         4'd0:    word = IP_WORD0 | 32'(olen_ff);
         4'd1:    word = 32'd0;
         4'd2:    word = {IP_TTL_PROTO, csum_ff};
         4'd3:    word = rd_rec_ff.src_addr;
         4'd4:    word = rd_rec_ff.dst_addr;
         4'd5:    word = {rd_rec_ff.sport, rd_rec_ff.dport};
         4'd6:    word = {olen_ff - IP_HDR_LEN, 16'd0};
         4'd7:    word = is_wg ? WG_TYPE_WORD : VXLAN_FLAGS;
         4'd8:    word = is_wg ? 32'd0 : {8'd0, cur_ff.idx, 8'd0};
         4'd9:    word = swap32(rd_ctr_ff[31:0]);
         default: word = swap32(rd_ctr_ff[63:32]);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      olen_in      = olen_ff;
      csum_in      = csum_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      pop          = 1'b0;
      ent_we       = 1'b0;
      ctr_we       = 1'b0;
      wr_addr      = head.idx[IDX_W-1:0];
      ctr_wd       = 64'd0;
      wr_rec.kind     = head.kind;
      wr_rec.src_addr = head.src_addr;
      wr_rec.dst_addr = head.dst_addr;
      wr_rec.sport    = head.sport;
      wr_rec.dport    = head.dport;
      wr_rec.iface    = head.iface;
      unique case (state_ff)
         B_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               cur_in = head;
               if (head.mode == OP_CREATE) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.last  = 1'b1;
                  if (head.flag) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     ent_we              = 1'b1;
                     ctr_we              = 1'b1;
                     rsp_in.status       = ST_CREATED;
                     rsp_in.kind         = head.kind;
                     rsp_in.out_iface    = head.iface;
                     rsp_in.tunnel_index = head.idx[11:0];
                  end
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            if (cur_ff.flag || (rd_rec_ff.kind != KIND_WG && rd_rec_ff.kind != KIND_VXLAN)) begin
               rsp_valid_in        = 1'b1;
               rsp_in.last         = 1'b1;
               rsp_in.status       = ST_PASS;
               rsp_in.out_len      = cur_ff.in_len;
               rsp_in.tunnel_index = cur_ff.idx[11:0];
               state_in            = B_IDLE;
            end else begin
               olen_in  = cur_ff.in_len + (is_wg ? WG_OVERHEAD : VXLAN_OVERHEAD);
               state_in = B_SUM;
            end
         end
         B_SUM: begin
            csum_in  = ip_checksum(olen_ff, rd_rec_ff.src_addr, rd_rec_ff.dst_addr);
            k_in     = 4'd0;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.header_word  = word;
            rsp_in.last         = (k_ff == last_k);
            rsp_in.status       = ST_HEADER;
            rsp_in.kind         = rd_rec_ff.kind;
            rsp_in.out_len      = olen_ff;
            rsp_in.out_iface    = rd_rec_ff.iface;
            rsp_in.tunnel_index = cur_ff.idx[11:0];
            k_in                = k_ff + 4'd1;
            if (k_ff == last_k) begin
               state_in = B_IDLE;
               wr_addr  = cur_ff.idx[IDX_W-1:0];
               ctr_we   = is_wg;
               ctr_wd   = rd_ctr_ff + 64'd1;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule
